@@ src/hemb_pkg.sv @@
// ----------------------------------------------------------------------------
// Half-edge mesh builder package
// Item codes, status codes and the fixed field widths of the block's ports.
// ----------------------------------------------------------------------------
package hemb_pkg;

  localparam int KIND_W  = 2;
  localparam int VERT_W  = 11;
  localparam int INDEX_W = 12;
  localparam int FACE_W  = 10;
  localparam int TWIN_W  = 13;
  localparam int COUNT_W = 11;

  typedef enum logic [KIND_W-1:0] {
    KIND_LOAD      = 2'd0,
    KIND_BUILD     = 2'd1,
    KIND_READ_EDGE = 2'd2,
    KIND_READ_VERT = 2'd3
  } kind_e;

  typedef enum logic [1:0] {
    ST_OK      = 2'd0,
    ST_FULL    = 2'd1,
    ST_RANGE   = 2'd2,
    ST_UNBUILT = 2'd3
  } status_e;

endpackage

@@ src/hemb_ram.sv @@
// ----------------------------------------------------------------------------
// Generic simple dual-port RAM
// One write port and one read port; the read data is registered.
// ----------------------------------------------------------------------------
module hemb_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                                   clk_i,
  input  logic                                   we_i,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr_i,
  input  logic [WIDTH-1:0]                       wdata_i,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr_i,
  output logic [WIDTH-1:0]                       rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule

@@ src/half_edge_mesh_builder.sv @@
// ----------------------------------------------------------------------------
// Half-edge mesh builder
// Loads triangles, links twin half-edges on request and answers reads.
// ----------------------------------------------------------------------------
// Faces, twins and per-vertex outgoing edges live in three synchronous RAMs.
// After reset the block clears the vertex RAM and accepts no item during
// that pass. One item is handled at a time. In a load, the face write shares
// a cycle with the first of three vertex writes. A read waits on the registered
// RAM read. A build with n = 3 * F half-edges first rewrites n twin entries,
// then for each edge still unlinked scans the face RAM face by face. The
// result sits in an output register while the next item is accepted.
// ----------------------------------------------------------------------------
module half_edge_mesh_builder #(
  parameter int MAX_FACES    = 1024,
  parameter int MAX_VERTICES = 2048
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           in_valid_i,
  output logic                           in_ready_o,
  input  logic [hemb_pkg::KIND_W-1:0]    kind_i,
  input  logic [hemb_pkg::VERT_W-1:0]    vert_a_i,
  input  logic [hemb_pkg::VERT_W-1:0]    vert_b_i,
  input  logic [hemb_pkg::VERT_W-1:0]    vert_c_i,
  input  logic [hemb_pkg::INDEX_W-1:0]   index_i,
  output logic                           out_valid_o,
  input  logic                           out_ready_i,
  output logic [1:0]                     status_o,
  output logic [hemb_pkg::VERT_W-1:0]    head_vertex_o,
  output logic [hemb_pkg::FACE_W-1:0]    owner_face_o,
  output logic [hemb_pkg::INDEX_W-1:0]   next_edge_o,
  output logic [hemb_pkg::TWIN_W-1:0]    twin_edge_o,
  output logic [hemb_pkg::INDEX_W-1:0]   vertex_edge_o,
  output logic                           vertex_edge_valid_o,
  output logic [hemb_pkg::COUNT_W-1:0]   face_count_o
);

  import hemb_pkg::*;

  localparam int FW    = (MAX_FACES > 1) ? $clog2(MAX_FACES) : 1;
  localparam int EW    = $clog2(3 * MAX_FACES);
  localparam int VW    = $clog2(MAX_VERTICES);
  localparam int CW    = $clog2(MAX_FACES + 1);
  localparam int TW    = EW + 1;
  localparam int EDGES = 3 * MAX_FACES;
  // Reciprocal of three for the half-edge to face split.
  localparam int SH    = EW + 2;
  localparam int RECIP = (2 ** SH) / 3 + 1;
  localparam int PW    = EW + SH;

  localparam logic [TW-1:0] TWIN_UNASG = {{(TW - 1){1'b1}}, 1'b0};
  localparam logic [TW-1:0] TWIN_NONE  = {TW{1'b1}};

  typedef enum logic [3:0] {
    S_CLR, S_IDLE, S_EXEC, S_L0, S_L1, S_L2, S_HRD, S_BCLR,
    S_BRD, S_BCHK, S_SRD, S_SCMP, S_WR1, S_WR2, S_FIN
  } state_e;

  state_e              state_q;
  kind_e               kind_q;
  logic [VERT_W-1:0]   va_q, vb_q, vc_q;
  logic [INDEX_W-1:0]  idx_q;
  status_e             st_q;
  logic [CW-1:0]       loaded_q;
  logic                built_q;
  logic [VW-1:0]       clr_q;
  logic [FW-1:0]       ef_q, kf_q, q_q;
  logic [1:0]          ei_q, r_q;
  logic [VW-1:0]       t0_q, h0_q;
  logic [TW-1:0]       found_q;

  logic                out_valid_q;
  logic [1:0]          status_q;
  logic [VERT_W-1:0]   head_q;
  logic [FACE_W-1:0]   face_q;
  logic [INDEX_W-1:0]  next_q;
  logic [TWIN_W-1:0]   twin_q;
  logic [INDEX_W-1:0]  vedge_q;
  logic                vvalid_q;
  logic [COUNT_W-1:0]  count_q;

  // RAM ports
  logic                face_we;
  logic [FW-1:0]       face_waddr, face_raddr;
  logic [3*VW-1:0]     face_wdata, face_rdata;
  logic                twin_we;
  logic [EW-1:0]       twin_waddr, twin_raddr;
  logic [TW-1:0]       twin_wdata, twin_rdata;
  logic                vert_we;
  logic [VW-1:0]       vert_waddr, vert_raddr;
  logic [EW:0]         vert_wdata, vert_rdata;

  logic [VW-1:0]       row_v [3];
  logic [EW-1:0]       cur_edge, face_edge0;
  logic                last_face, last_scan, out_free;
  logic [PW-1:0]       prod;
  logic [EW-1:0]       idx_e;
  logic [1:0]          r_nxt, ei_nxt;
  logic [2:0]          hit;

  assign row_v[0] = face_rdata[VW-1:0];
  assign row_v[1] = face_rdata[2*VW-1:VW];
  assign row_v[2] = face_rdata[3*VW-1:2*VW];

  assign cur_edge   = EW'(32'(ef_q) * 3 + 32'(ei_q));
  assign face_edge0 = EW'(32'(kf_q) * 3);
  assign last_face  = (32'(ef_q) + 1 == 32'(loaded_q));
  assign last_scan  = (32'(kf_q) + 1 == 32'(loaded_q));
  assign out_free   = !out_valid_q || out_ready_i;
  assign idx_e      = EW'(idx_q);
  assign prod       = PW'(idx_e) * PW'(RECIP);
  assign r_nxt      = (r_q == 2'd2) ? 2'd0 : r_q + 2'd1;
  assign ei_nxt     = (ei_q == 2'd2) ? 2'd0 : ei_q + 2'd1;

  // Edge i of the scanned face runs from row_v[i] to row_v[i+1 mod 3].
  assign hit[0] = (row_v[0] == h0_q) && (row_v[1] == t0_q);
  assign hit[1] = (row_v[1] == h0_q) && (row_v[2] == t0_q);
  assign hit[2] = (row_v[2] == h0_q) && (row_v[0] == t0_q);

  assign in_ready_o = (state_q == S_IDLE);

  always_comb begin
    face_we    = (state_q == S_L0);
    face_waddr = FW'(loaded_q);
    face_wdata = {VW'(vc_q), VW'(vb_q), VW'(va_q)};
    if (state_q == S_SRD) begin
      face_raddr = kf_q;
    end else if (kind_q == KIND_READ_EDGE) begin
      face_raddr = q_q;
    end else begin
      face_raddr = ef_q;
    end

    twin_we    = 1'b0;
    twin_waddr = cur_edge;
    twin_wdata = TWIN_UNASG;
    case (state_q)
      S_BCLR: begin
        twin_we = 1'b1;
      end
      S_WR1: begin
        twin_we    = 1'b1;
        twin_wdata = found_q;
      end
      S_WR2: begin
        twin_we    = 1'b1;
        twin_waddr = EW'(found_q);
        twin_wdata = TW'(cur_edge);
      end
      default: ;
    endcase
    twin_raddr = (kind_q == KIND_READ_EDGE) ? idx_e : cur_edge;

    vert_we    = 1'b1;
    vert_waddr = clr_q;
    vert_wdata = '0;
    case (state_q)
      S_CLR: ;
      S_L0: begin
        vert_waddr = VW'(va_q);
        vert_wdata = {1'b1, EW'(32'(loaded_q) * 3)};
      end
      S_L1: begin
        vert_waddr = VW'(vb_q);
        vert_wdata = {1'b1, EW'(32'(loaded_q) * 3 + 1)};
      end
      S_L2: begin
        vert_waddr = VW'(vc_q);
        vert_wdata = {1'b1, EW'(32'(loaded_q) * 3 + 2)};
      end
      default: vert_we = 1'b0;
    endcase
    vert_raddr = VW'(idx_q);
  end

  hemb_ram #(.WIDTH(3 * VW), .DEPTH(MAX_FACES)) u_face_ram (
    .clk_i   (clk_i),
    .we_i    (face_we),
    .waddr_i (face_waddr),
    .wdata_i (face_wdata),
    .raddr_i (face_raddr),
    .rdata_o (face_rdata)
  );

  hemb_ram #(.WIDTH(TW), .DEPTH(EDGES)) u_twin_ram (
    .clk_i   (clk_i),
    .we_i    (twin_we),
    .waddr_i (twin_waddr),
    .wdata_i (twin_wdata),
    .raddr_i (twin_raddr),
    .rdata_o (twin_rdata)
  );

  hemb_ram #(.WIDTH(EW + 1), .DEPTH(MAX_VERTICES)) u_vert_ram (
    .clk_i   (clk_i),
    .we_i    (vert_we),
    .waddr_i (vert_waddr),
    .wdata_i (vert_wdata),
    .raddr_i (vert_raddr),
    .rdata_o (vert_rdata)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_CLR;
      loaded_q    <= '0;
      built_q     <= 1'b0;
      clr_q       <= '0;
      out_valid_q <= 1'b0;
      count_q     <= '0;
      kind_q      <= KIND_LOAD;
      st_q        <= ST_OK;
    end else begin
      if (out_valid_q && out_ready_i && state_q != S_FIN) begin
        out_valid_q <= 1'b0;
      end
      case (state_q)
        S_CLR: begin
          clr_q <= clr_q + 1'b1;
          if (32'(clr_q) == MAX_VERTICES - 1) begin
            state_q <= S_IDLE;
          end
        end
        S_IDLE: begin
          if (in_valid_i) begin
            kind_q  <= kind_e'(kind_i);
            va_q    <= vert_a_i;
            vb_q    <= vert_b_i;
            vc_q    <= vert_c_i;
            idx_q   <= index_i;
            state_q <= S_EXEC;
          end
        end
        S_EXEC: begin
          st_q    <= ST_OK;
          ef_q    <= '0;
          ei_q    <= '0;
          state_q <= S_FIN;
          case (kind_q)
            KIND_LOAD: begin
              if (32'(loaded_q) >= MAX_FACES) begin
                st_q <= ST_FULL;
              end else if (32'(va_q) >= MAX_VERTICES || 32'(vb_q) >= MAX_VERTICES ||
                           32'(vc_q) >= MAX_VERTICES) begin
                st_q <= ST_RANGE;
              end else begin
                state_q <= S_L0;
              end
            end
            KIND_BUILD: begin
              if (loaded_q == '0) begin
                built_q <= 1'b1;
              end else begin
                state_q <= S_BCLR;
              end
            end
            KIND_READ_EDGE: begin
              if (32'(idx_q) >= 32'(loaded_q) * 3) begin
                st_q <= ST_RANGE;
              end else begin
                q_q     <= FW'(prod[PW-1:SH]);
                r_q     <= 2'(idx_e - EW'(32'(prod[PW-1:SH]) * 3));
                st_q    <= built_q ? ST_OK : ST_UNBUILT;
                state_q <= S_HRD;
              end
            end
            default: begin
              if (32'(idx_q) >= MAX_VERTICES) begin
                st_q <= ST_RANGE;
              end
            end
          endcase
        end
        S_L0: state_q <= S_L1;
        S_L1: state_q <= S_L2;
        S_L2: begin
          loaded_q <= loaded_q + 1'b1;
          built_q  <= 1'b0;
          state_q  <= S_FIN;
        end
        S_HRD: state_q <= S_FIN;
        S_BCLR: begin
          ei_q <= ei_nxt;
          if (ei_q == 2'd2) begin
            if (last_face) begin
              ef_q    <= '0;
              state_q <= S_BRD;
            end else begin
              ef_q <= ef_q + 1'b1;
            end
          end
        end
        S_BRD: state_q <= S_BCHK;
        S_BCHK: begin
          if (twin_rdata != TWIN_UNASG) begin
            ei_q <= ei_nxt;
            if (ei_q == 2'd2) begin
              if (last_face) begin
                built_q <= 1'b1;
                state_q <= S_FIN;
              end else begin
                ef_q    <= ef_q + 1'b1;
                state_q <= S_BRD;
              end
            end else begin
              state_q <= S_BRD;
            end
          end else begin
            t0_q    <= row_v[ei_q];
            h0_q    <= row_v[ei_nxt];
            kf_q    <= '0;
            state_q <= S_SRD;
          end
        end
        S_SRD: state_q <= S_SCMP;
        S_SCMP: begin
          if (hit[0]) begin
            found_q <= TW'(face_edge0);
            state_q <= S_WR1;
          end else if (hit[1]) begin
            found_q <= TW'(face_edge0 + EW'(1));
            state_q <= S_WR1;
          end else if (hit[2]) begin
            found_q <= TW'(face_edge0 + EW'(2));
            state_q <= S_WR1;
          end else if (last_scan) begin
            found_q <= TWIN_NONE;
            state_q <= S_WR1;
          end else begin
            kf_q    <= kf_q + 1'b1;
            state_q <= S_SRD;
          end
        end
        S_WR1, S_WR2: begin
          if (state_q == S_WR1 && found_q != TWIN_NONE) begin
            state_q <= S_WR2;
          end else begin
            ei_q <= ei_nxt;
            if (ei_q == 2'd2) begin
              if (last_face) begin
                built_q <= 1'b1;
                state_q <= S_FIN;
              end else begin
                ef_q    <= ef_q + 1'b1;
                state_q <= S_BRD;
              end
            end else begin
              state_q <= S_BRD;
            end
          end
        end
        S_FIN: begin
          if (out_free) begin
            out_valid_q <= 1'b1;
            status_q    <= st_q;
            count_q     <= COUNT_W'(loaded_q);
            head_q      <= '0;
            face_q      <= '0;
            next_q      <= '0;
            twin_q      <= '0;
            vedge_q     <= '0;
            vvalid_q    <= 1'b0;
            if (kind_q == KIND_READ_EDGE && st_q != ST_RANGE) begin
              head_q <= VERT_W'(row_v[r_nxt]);
              face_q <= FACE_W'(q_q);
              next_q <= INDEX_W'(32'(q_q) * 3 + 32'(r_nxt));
              twin_q <= (st_q == ST_OK) ? TWIN_W'($signed(twin_rdata))
                                        : TWIN_W'($signed(TWIN_NONE));
            end
            if (kind_q == KIND_READ_VERT && st_q == ST_OK && vert_rdata[EW]) begin
              vedge_q  <= INDEX_W'(vert_rdata[EW-1:0]);
              vvalid_q <= 1'b1;
            end
            state_q <= S_IDLE;
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  assign out_valid_o         = out_valid_q;
  assign status_o            = status_q;
  assign head_vertex_o       = head_q;
  assign owner_face_o        = face_q;
  assign next_edge_o         = next_q;
  assign twin_edge_o         = twin_q;
  assign vertex_edge_o       = vedge_q;
  assign vertex_edge_valid_o = vvalid_q;
  assign face_count_o        = count_q;

endmodule

@@ dv/hemb_mesh_checker.sv @@
// ----------------------------------------------------------------------------
// Half-edge mesh checker
// Watches both channels, keeps its own copy of the mesh tables to predict
// every reply, and compares each accepted reply field by field.
// ----------------------------------------------------------------------------
module hemb_mesh_checker
  import hemb_pkg::*;
#(
  parameter int MAX_FACES    = 1024,
  parameter int MAX_VERTICES = 2048
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  input  logic                 in_ready_i,
  input  logic [KIND_W-1:0]    kind_i,
  input  logic [VERT_W-1:0]    vert_a_i,
  input  logic [VERT_W-1:0]    vert_b_i,
  input  logic [VERT_W-1:0]    vert_c_i,
  input  logic [INDEX_W-1:0]   index_i,
  input  logic                 out_valid_i,
  input  logic                 out_ready_i,
  input  logic [1:0]           status_i,
  input  logic [VERT_W-1:0]    head_vertex_i,
  input  logic [FACE_W-1:0]    owner_face_i,
  input  logic [INDEX_W-1:0]   next_edge_i,
  input  logic [TWIN_W-1:0]    twin_edge_i,
  input  logic [INDEX_W-1:0]   vertex_edge_i,
  input  logic                 vertex_edge_valid_i,
  input  logic [COUNT_W-1:0]   face_count_i,
  output int                   mismatch_count_o,
  output int                   pending_o
);

  localparam int UNLINKED = -2;
  localparam int NO_TWIN  = -1;

  typedef struct packed {
    status_e             status;
    logic [VERT_W-1:0]   head;
    logic [FACE_W-1:0]   face;
    logic [INDEX_W-1:0]  next;
    logic [TWIN_W-1:0]   twin;
    logic [INDEX_W-1:0]  vedge;
    logic                vvalid;
    logic [COUNT_W-1:0]  count;
  } mesh_reply_t;

  int unsigned face_vert [MAX_FACES][3];
  int          twin_of   [3*MAX_FACES];
  int unsigned vert_out  [MAX_VERTICES];
  bit          vert_used [MAX_VERTICES];
  int unsigned num_faces;
  bit          linked;
  int          fail_count = 0;
  int          pending_count = 0;

  mesh_reply_t expected_replies[$];

  assign mismatch_count_o = fail_count;
  assign pending_o        = pending_count;

  function automatic int unsigned tail_of(int unsigned e);
    return face_vert[e/3][e%3];
  endfunction

  function automatic int unsigned head_of(int unsigned e);
    return face_vert[e/3][(e%3+1)%3];
  endfunction

  function automatic void link_twins();
    int unsigned n;
    int found;
    n = 3 * num_faces;
    for (int unsigned e = 0; e < n; e++) twin_of[e] = UNLINKED;
    for (int unsigned e = 0; e < n; e++) begin
      if (twin_of[e] != UNLINKED) continue;
      found = NO_TWIN;
      for (int unsigned k = 0; k < n; k++) begin
        if (tail_of(k) == head_of(e) && head_of(k) == tail_of(e)) begin
          found = k;
          break;
        end
      end
      twin_of[e] = found;
      if (found != NO_TWIN) twin_of[found] = e;
    end
    linked = 1'b1;
  endfunction

  function automatic mesh_reply_t predict_mesh_item(kind_e kind, int unsigned va,
      int unsigned vb, int unsigned vc, int unsigned idx);
    mesh_reply_t r;
    int unsigned v[3];
    int unsigned e;
    r = '0;
    r.status = ST_OK;
    v[0] = va; v[1] = vb; v[2] = vc;
    case (kind)
      KIND_LOAD: begin
        if (num_faces >= MAX_FACES) r.status = ST_FULL;
        else if (va >= MAX_VERTICES || vb >= MAX_VERTICES || vc >= MAX_VERTICES)
          r.status = ST_RANGE;
        else begin
          for (int i = 0; i < 3; i++) begin
            e = 3 * num_faces + i;
            face_vert[num_faces][i] = v[i];
            twin_of[e] = UNLINKED;
            vert_out[v[i]] = e;
            vert_used[v[i]] = 1'b1;
          end
          num_faces++;
          linked = 1'b0;
        end
      end
      KIND_BUILD: link_twins();
      KIND_READ_EDGE: begin
        if (idx >= 3 * num_faces) r.status = ST_RANGE;
        else begin
          r.head = VERT_W'(head_of(idx));
          r.face = FACE_W'(idx / 3);
          r.next = INDEX_W'(3 * (idx / 3) + (idx % 3 + 1) % 3);
          if (linked) r.twin = TWIN_W'(twin_of[idx]);
          else begin
            r.status = ST_UNBUILT;
            r.twin = TWIN_W'(NO_TWIN);
          end
        end
      end
      default: begin
        if (idx >= MAX_VERTICES) r.status = ST_RANGE;
        else if (vert_used[idx]) begin
          r.vedge = INDEX_W'(vert_out[idx]);
          r.vvalid = 1'b1;
        end
      end
    endcase
    r.count = COUNT_W'(num_faces);
    return r;
  endfunction

  task automatic report(string what, int got, int want);
    $display("[%0t] mismatch on %s: got %0d, expected %0d", $time, what, got, want);
    fail_count++;
  endtask

  always @(posedge clk_i) begin
    mesh_reply_t want;
    mesh_reply_t pred;
    if (!rst_ni) begin
      num_faces = 0;
      linked = 1'b0;
      for (int e = 0; e < 3*MAX_FACES; e++) twin_of[e] = UNLINKED;
      for (int v = 0; v < MAX_VERTICES; v++) vert_used[v] = 1'b0;
      expected_replies.delete();
    end else begin
      // A transaction accepted on the input side is queued before the output
      // side is looked at, so same-edge traffic never looks unexpected.
      if (in_valid_i && in_ready_i) begin
        pred = predict_mesh_item(kind_e'(kind_i), 32'(vert_a_i), 32'(vert_b_i),
            32'(vert_c_i), 32'(index_i));
        expected_replies = {expected_replies, pred};
      end
      if (out_valid_i && out_ready_i) begin
        if (expected_replies.size() == 0) report("unexpected reply", 1, 0);
        else begin
          want = expected_replies.pop_front();
          if (status_i != want.status)
            report("status", int'(status_i), int'(want.status));
          if (head_vertex_i != want.head)
            report("head_vertex", int'(head_vertex_i), int'(want.head));
          if (owner_face_i != want.face)
            report("owner_face", int'(owner_face_i), int'(want.face));
          if (next_edge_i != want.next)
            report("next_edge", int'(next_edge_i), int'(want.next));
          if (twin_edge_i != want.twin)
            report("twin_edge", int'($signed(twin_edge_i)), int'($signed(want.twin)));
          if (vertex_edge_i != want.vedge)
            report("vertex_edge", int'(vertex_edge_i), int'(want.vedge));
          if (vertex_edge_valid_i != want.vvalid)
            report("vertex_edge_valid", int'(vertex_edge_valid_i), int'(want.vvalid));
          if (face_count_i != want.count)
            report("face_count", int'(face_count_i), int'(want.count));
        end
      end
    end
    pending_count = expected_replies.size();
  end

endmodule

@@ dv/tb_half_edge_mesh_builder.sv @@
// ----------------------------------------------------------------------------
// Half-edge mesh builder testbench
// Drives loads, twin builds and reads with random gaps and back-pressure;
// the mesh checker predicts and compares every reply.
// ----------------------------------------------------------------------------
module tb_half_edge_mesh_builder;
  import hemb_pkg::*;

  localparam int MAX_FACES    = 1024;
  localparam int MAX_VERTICES = 2048;
  localparam int CYCLE_LIMIT  = 4000000;
  localparam int SMALL_MESH   = 60;

  logic                clk_i = 1'b0;
  logic                rst_ni = 1'b0;
  logic                in_valid = 1'b0;
  logic                in_ready;
  logic [KIND_W-1:0]   kind = KIND_LOAD;
  logic [VERT_W-1:0]   vert_a = '0, vert_b = '0, vert_c = '0;
  logic [INDEX_W-1:0]  index = '0;
  logic                out_valid;
  logic                out_ready = 1'b0;
  logic [1:0]          status;
  logic [VERT_W-1:0]   head_vertex;
  logic [FACE_W-1:0]   owner_face;
  logic [INDEX_W-1:0]  next_edge;
  logic [TWIN_W-1:0]   twin_edge;
  logic [INDEX_W-1:0]  vertex_edge;
  logic                vertex_edge_valid;
  logic [COUNT_W-1:0]  face_count;
  int                  mismatches, pending;

  bit          calm;
  int unsigned cycles, faces_sent, loads, builds, reads;
  int unsigned prev_a, prev_b, prev_c;

  always begin
    #10 clk_i = 1'b1;
    #10 clk_i = 1'b0;
  end

  half_edge_mesh_builder #(.MAX_FACES(MAX_FACES), .MAX_VERTICES(MAX_VERTICES)) DUT (
    .clk_i, .rst_ni,
    .in_valid_i(in_valid), .in_ready_o(in_ready),
    .kind_i(kind), .vert_a_i(vert_a), .vert_b_i(vert_b), .vert_c_i(vert_c),
    .index_i(index),
    .out_valid_o(out_valid), .out_ready_i(out_ready),
    .status_o(status), .head_vertex_o(head_vertex), .owner_face_o(owner_face),
    .next_edge_o(next_edge), .twin_edge_o(twin_edge), .vertex_edge_o(vertex_edge),
    .vertex_edge_valid_o(vertex_edge_valid), .face_count_o(face_count)
  );

  hemb_mesh_checker #(.MAX_FACES(MAX_FACES), .MAX_VERTICES(MAX_VERTICES)) u_checker (
    .clk_i, .rst_ni,
    .in_valid_i(in_valid), .in_ready_i(in_ready),
    .kind_i(kind), .vert_a_i(vert_a), .vert_b_i(vert_b), .vert_c_i(vert_c),
    .index_i(index),
    .out_valid_i(out_valid), .out_ready_i(out_ready),
    .status_i(status), .head_vertex_i(head_vertex), .owner_face_i(owner_face),
    .next_edge_i(next_edge), .twin_edge_i(twin_edge), .vertex_edge_i(vertex_edge),
    .vertex_edge_valid_i(vertex_edge_valid), .face_count_i(face_count),
    .mismatch_count_o(mismatches), .pending_o(pending)
  );

  always @(negedge clk_i) out_ready <= calm || ($urandom_range(99) >= 19);

  always @(posedge clk_i) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles", cycles);
      $display("end of test: mismatches");
      $finish;
    end
  end

  // Valid is raised at a falling edge and held until the transaction completes.
  task automatic send(kind_e k, int unsigned a, int unsigned b,
      int unsigned c, int unsigned idx);
    @(negedge clk_i);
    if (!calm && $urandom_range(99) < 19) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(4, 1)) @(negedge clk_i);
    end
    in_valid <= 1'b1;
    kind <= k;
    vert_a <= VERT_W'(a); vert_b <= VERT_W'(b); vert_c <= VERT_W'(c);
    index <= INDEX_W'(idx);
    do @(posedge clk_i); while (!in_ready);
    case (k)
      KIND_LOAD: begin
        loads++;
        if (faces_sent < MAX_FACES) faces_sent++;
        prev_a = a; prev_b = b; prev_c = c;
      end
      KIND_BUILD: builds++;
      default: reads++;
    endcase
  endtask

  function automatic int unsigned pick_vertex();
    int unsigned r;
    r = $urandom_range(99);
    if (r < 70) return $urandom_range(11);
    if (r < 90) return $urandom_range(MAX_VERTICES - 1);
    return (r < 95) ? 0 : MAX_VERTICES - 1;
  endfunction

  task automatic random_item(bit allow_load, bit allow_build);
    int unsigned r, span;
    r = $urandom_range(99);
    span = 3 * faces_sent + 3;
    if (r < 3 && allow_build) send(KIND_BUILD, $urandom, $urandom, $urandom, $urandom);
    else if (r < 38 && allow_load) begin
      // Reversed copies of the last triangle give shared edges and twins.
      if ($urandom_range(3) == 0) send(KIND_LOAD, prev_a, prev_c, prev_b, $urandom);
      else send(KIND_LOAD, pick_vertex(), pick_vertex(), pick_vertex(), $urandom);
    end else if (r < 70)
      send(KIND_READ_EDGE, $urandom, $urandom, $urandom,
           ($urandom_range(9) == 0) ? $urandom : $urandom_range(span - 1));
    else
      send(KIND_READ_VERT, $urandom, $urandom, $urandom,
           ($urandom_range(7) == 0) ? $urandom : pick_vertex());
  endtask

  initial begin
    calm = 1'b0;
    prev_a = 0; prev_b = 0; prev_c = 0;
    repeat (3) @(posedge clk_i);
    @(negedge clk_i) rst_ni <= 1'b1;

    // Directed: empty mesh, extremes, degenerate and shared edges.
    send(KIND_BUILD, '0, '0, '0, '0);
    send(KIND_READ_EDGE, '0, '0, '0, '0);
    send(KIND_READ_VERT, '0, '0, '0, '0);
    send(KIND_READ_VERT, '0, '0, '0, '1);
    send(KIND_READ_VERT, '0, '0, '0, 12'd2048);
    send(KIND_LOAD, '0, 11'd2047, 11'd1, '1);
    send(KIND_READ_EDGE, '0, '0, '0, 12'd2);
    send(KIND_READ_EDGE, '0, '0, '0, 12'd3);
    send(KIND_LOAD, 11'd2047, '0, 11'd2, '0);
    send(KIND_LOAD, 11'd5, 11'd5, 11'd5, '0);
    send(KIND_LOAD, 11'd1, 11'd2047, '0, '0);
    send(KIND_BUILD, '1, '1, '1, '1);
    for (int e = 0; e < 12; e += 2) send(KIND_READ_EDGE, '0, '0, '0, e);
    send(KIND_READ_EDGE, '0, '0, '0, 12'd11);
    send(KIND_READ_VERT, '0, '0, '0, 12'd2047);
    send(KIND_READ_VERT, '0, '0, '0, 12'd5);
    send(KIND_READ_VERT, '0, '0, '0, 12'd7);
    send(KIND_LOAD, '0, 11'd1, 11'd2047, '0);
    send(KIND_READ_EDGE, '0, '0, '0, 12'd0);
    send(KIND_BUILD, '0, '0, '0, '0);
    send(KIND_READ_EDGE, '0, '0, '0, 12'd13);

    // Small meshes, where builds stay cheap.
    for (int n = 0; n < 160; n++) begin
      calm = (n >= 60 && n < 120);
      random_item(faces_sent < SMALL_MESH, 1'b1);
    end
    calm = 1'b0;
    send(KIND_BUILD, '0, '0, '0, '0);
    repeat (20) random_item(1'b0, 1'b0);

    // Fill the face table, try past it, then read the large mesh.
    while (faces_sent < MAX_FACES) send(KIND_LOAD, $urandom, $urandom, $urandom, $urandom);
    repeat (4) send(KIND_LOAD, $urandom, $urandom, $urandom, $urandom);
    send(KIND_READ_EDGE, '0, '0, '0, 12'd3071);
    repeat (40) random_item(1'b1, 1'b0);

    @(negedge clk_i) in_valid <= 1'b0;
    while (pending != 0) @(negedge clk_i);
    repeat (20) @(posedge clk_i);
    $display("covered %0d loads, %0d builds and %0d reads over %0d cycles",
             loads, builds, reads, cycles);
    if (mismatches == 0) $display("end of test: clean");
    else $display("end of test: mismatches");
    $finish;
  end

endmodule
